// ===== hdl/hid_key_report_change_events_top_defines.svh =====
`ifndef HID_KEY_REPORT_CHANGE_EVENTS_TOP_DEFINES_SVH
`define HID_KEY_REPORT_CHANGE_EVENTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define HKR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define HKR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define HKR_ASSERT(label, prop, msg)
`define HKR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== hdl/hkr_pkg.sv =====
`timescale 1ns / 1ps

package hkr_pkg;

    localparam int KEY_W = 16;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        EV_PRESS       = 2'd0,
        EV_RELEASE     = 2'd1,
        EV_MOD_PRESS   = 2'd2,
        EV_MOD_RELEASE = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic mod_press;
        logic mod_release;
    } mod_evt_t;

endpackage

// ===== hdl/hkr_front.sv =====
`timescale 1ns / 1ps

module hkr_front import hkr_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [KEY_SLOTS*KEY_W-1:0] in_keys,
    output logic                       job_valid,
    input  logic                       job_ready,
    output mod_evt_t                   job_mod,
    output logic [KEY_SLOTS-1:0]       job_press_pend,
    output logic [KEY_SLOTS-1:0]       job_rel_pend,
    output logic [KEY_SLOTS*KEY_W-1:0] job_rel_keys
);

    key_t                 held_key_reg [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] held_vld_reg;

    key_t                 slot  [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] fresh;
    logic [KEY_SLOTS-1:0] press;
    logic [KEY_SLOTS-1:0] rel;
    logic                 accept;
    logic                 has_event;

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            slot[i] = in_keys[i*KEY_W +: KEY_W];
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            fresh[i] = (slot[i] != '0);
            for (int j = 0; j < i; j++) begin
                if (slot[j] == slot[i]) begin
                    fresh[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            press[i] = fresh[i];
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (held_vld_reg[j] && held_key_reg[j] == slot[i]) begin
                    press[i] = 1'b0;
                end
            end
        end
        for (int j = 0; j < KEY_SLOTS; j++) begin
            rel[j] = held_vld_reg[j];
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (fresh[i] && slot[i] == held_key_reg[j]) begin
                    rel[j] = 1'b0;
                end
            end
            job_rel_keys[j*KEY_W +: KEY_W] = held_key_reg[j];
        end
    end

    assign job_mod.mod_press   = (held_vld_reg == '0) && (fresh != '0);
    assign job_mod.mod_release = (held_vld_reg != '0) && (fresh == '0);
    assign job_press_pend      = press;
    assign job_rel_pend        = rel;
    assign has_event           = (press != '0) || (rel != '0);
    assign in_ready            = job_ready;
    assign accept              = in_valid && job_ready;
    assign job_valid           = accept && has_event;

    // record the new held set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_vld_reg <= '0;
        end else if (accept) begin
            held_vld_reg <= fresh;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                held_key_reg[i] <= slot[i];
            end
        end
    end

endmodule

// ===== hdl/hkr_fifo.sv =====
`timescale 1ns / 1ps

module hkr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/hkr_back.sv =====
`timescale 1ns / 1ps
`include "hid_key_report_change_events_top_defines.svh"

module hkr_back import hkr_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  mod_evt_t                   job_mod,
    input  logic [KEY_SLOTS-1:0]       job_press_pend,
    input  logic [KEY_SLOTS*KEY_W-1:0] job_press_keys,
    input  logic [KEY_SLOTS-1:0]       job_rel_pend,
    input  logic [KEY_SLOTS*KEY_W-1:0] job_rel_keys,
    output logic                       out_valid,
    input  logic                       out_ready,
    output event_kind_t                out_kind,
    output key_t                       out_key,
    output logic                       out_last
);

    logic                 busy_reg,       busy_next;
    mod_evt_t             mod_reg,        mod_next;
    logic [KEY_SLOTS-1:0] press_pend_reg, press_pend_next;
    logic [KEY_SLOTS-1:0] rel_pend_reg,   rel_pend_next;
    key_t                 press_key_reg [KEY_SLOTS];
    key_t                 rel_key_reg   [KEY_SLOTS];
    logic                 out_valid_reg,  out_valid_next;
    event_kind_t          out_kind_reg,   out_kind_next;
    key_t                 out_key_reg,    out_key_next;
    logic                 out_last_reg,   out_last_next;

    logic [KEY_SLOTS-1:0] press_sel;
    logic [KEY_SLOTS-1:0] rel_sel;
    key_t                 press_min;
    key_t                 rel_min;
    logic                 issue;
    logic                 last_event;
    logic                 load;

    // pick the lowest pending code in each group
    always_comb begin
        press_min = '0;
        rel_min   = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            press_sel[i] = press_pend_reg[i];
            rel_sel[i]   = rel_pend_reg[i];
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (j != i && press_pend_reg[j] && press_key_reg[j] < press_key_reg[i]) begin
                    press_sel[i] = 1'b0;
                end
                if (j != i && rel_pend_reg[j] && rel_key_reg[j] < rel_key_reg[i]) begin
                    rel_sel[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            press_min = press_min | (press_sel[i] ? press_key_reg[i] : '0);
            rel_min   = rel_min   | (rel_sel[i]   ? rel_key_reg[i]   : '0);
        end
    end

    assign issue = busy_reg && (!out_valid_reg || out_ready);

    always_comb begin
        busy_next       = busy_reg;
        mod_next        = mod_reg;
        press_pend_next = press_pend_reg;
        rel_pend_next   = rel_pend_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;
        last_event      = 1'b0;

        if (issue) begin
            if (mod_reg.mod_press) begin
                out_kind_next      = EV_MOD_PRESS;
                out_key_next       = '0;
                mod_next.mod_press = 1'b0;
            end else if (press_pend_reg != '0) begin
                out_kind_next   = EV_PRESS;
                out_key_next    = press_min;
                press_pend_next = press_pend_reg & ~press_sel;
            end else if (rel_pend_reg != '0) begin
                out_kind_next = EV_RELEASE;
                out_key_next  = rel_min;
                rel_pend_next = rel_pend_reg & ~rel_sel;
            end else begin
                out_kind_next        = EV_MOD_RELEASE;
                out_key_next         = '0;
                mod_next.mod_release = 1'b0;
            end
            last_event = !mod_next.mod_press && !mod_next.mod_release
                         && (press_pend_next == '0) && (rel_pend_next == '0);
            out_valid_next = 1'b1;
            out_last_next  = last_event;
            if (last_event) begin
                busy_next = 1'b0;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (load) begin
            busy_next       = 1'b1;
            mod_next        = job_mod;
            press_pend_next = job_press_pend;
            rel_pend_next   = job_rel_pend;
        end
    end

    assign job_ready = !busy_reg || (issue && last_event);
    assign load      = job_valid && job_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            mod_reg        <= '0;
            press_pend_reg <= '0;
            rel_pend_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            mod_reg        <= mod_next;
            press_pend_reg <= press_pend_next;
            rel_pend_reg   <= rel_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
        if (load) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                press_key_reg[i] <= job_press_keys[i*KEY_W +: KEY_W];
                rel_key_reg[i]   <= job_rel_keys[i*KEY_W +: KEY_W];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_key   = out_key_reg;
    assign out_last  = out_last_reg;

    `HKR_ASSERT(a_press_sel_onehot, $onehot0(press_sel), "press selection not one-hot")
    `HKR_ASSERT(a_rel_sel_onehot, $onehot0(rel_sel), "release selection not one-hot")
    `HKR_ASSERT(a_idle_clear,
        !busy_reg |-> (press_pend_reg == '0 && rel_pend_reg == '0 && mod_reg == '0),
        "idle with pending events")
    `HKR_ASSERT_NEVER(a_mod_both, mod_reg.mod_press && mod_reg.mod_release, "modifier press and release together")

endmodule

// ===== hdl/hid_key_report_change_events_top.sv =====
`timescale 1ns / 1ps
// Channel  Dir  tdata                          tuser            tlast
// s_axis   in   key_slot_0 .. key_slot_N-1     -                -
// m_axis   out  event_key                      event_kind       last_event
//
// Each report taken yields 0 to 2*KEY_SLOTS events.
// Reports follow each other in consecutive cycles while the two-entry job queue has room.
// Event issue rate is set by the back part: one event per cycle from the min-select over
// pending keys, unless m_axis_tready stalls; a report holds it until its last event.
// Reset (aresetn low, synchronous) empties the held set, the queue and the output register.
// m_axis_tready low stalls only the back part; the front keeps taking reports until full.

module hid_key_report_change_events_top import hkr_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [KEY_SLOTS*KEY_W-1:0] s_axis_tdata,   // key_slot_0 .. key_slot_N-1
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [KEY_W-1:0]           m_axis_tdata,   // event_key
    output logic [1:0]                 m_axis_tuser,   // event_kind
    output logic                       m_axis_tlast
);

    localparam int JOB_W = 2 + 2 * KEY_SLOTS * (KEY_W + 1);

    mod_evt_t                   f_mod;
    logic [KEY_SLOTS-1:0]       f_press_pend;
    logic [KEY_SLOTS-1:0]       f_rel_pend;
    logic [KEY_SLOTS*KEY_W-1:0] f_rel_keys;
    logic                       f_valid;
    logic                       f_ready;

    logic [JOB_W-1:0]           wr_job;
    logic [JOB_W-1:0]           rd_job;
    logic                       q_valid;
    logic                       q_ready;

    mod_evt_t                   b_mod;
    logic [KEY_SLOTS-1:0]       b_press_pend;
    logic [KEY_SLOTS*KEY_W-1:0] b_press_keys;
    logic [KEY_SLOTS-1:0]       b_rel_pend;
    logic [KEY_SLOTS*KEY_W-1:0] b_rel_keys;
    event_kind_t                out_kind;

    hkr_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_keys        (s_axis_tdata),
        .job_valid      (f_valid),
        .job_ready      (f_ready),
        .job_mod        (f_mod),
        .job_press_pend (f_press_pend),
        .job_rel_pend   (f_rel_pend),
        .job_rel_keys   (f_rel_keys)
    );

    assign wr_job = {f_mod, f_press_pend, s_axis_tdata, f_rel_pend, f_rel_keys};

    hkr_fifo #(.WIDTH(JOB_W)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (wr_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (rd_job)
    );

    assign {b_mod, b_press_pend, b_press_keys, b_rel_pend, b_rel_keys} = rd_job;

    hkr_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (q_valid),
        .job_ready      (q_ready),
        .job_mod        (b_mod),
        .job_press_pend (b_press_pend),
        .job_press_keys (b_press_keys),
        .job_rel_pend   (b_rel_pend),
        .job_rel_keys   (b_rel_keys),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_kind       (out_kind),
        .out_key        (m_axis_tdata),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;

endmodule

// ===== tb/hid_key_report_change_events_top_tb.sv =====
`timescale 1ns / 1ps

module hid_key_report_change_events_top_tb import hkr_pkg::*;;

    localparam int SLOTS = 6;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_REPORTS = 250;

    typedef logic [SLOTS*KEY_W-1:0] report_t;

    typedef struct packed {
        event_kind_t kind;
        key_t        code;
        logic        is_last;
    } key_event_t;

    typedef struct packed {
        logic       typed;
        logic [1:0] n;
        key_event_t e0;
        key_event_t e1;
        report_t    rpt;
    } report_row_t;

    logic    aclk;
    logic    aresetn;
    logic    s_axis_tvalid;
    logic    s_axis_tready;
    report_t s_axis_tdata;
    logic    m_axis_tvalid;
    logic    m_axis_tready;
    key_t    m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic    m_axis_tlast;

    key_t        held_set[$];
    key_event_t  predicted_events[$];
    key_event_t  pending_events[$];
    report_row_t directed_reports[$];
    key_event_t  want;
    int          mismatches;
    logic        quiet;

    hid_key_report_change_events_top #(.KEY_SLOTS(SLOTS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit has_key(input key_t keys[$], input key_t k);
        foreach (keys[i])
            if (keys[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic key_event_t ev(input event_kind_t kind, input key_t code,
                                      input logic is_last);
        key_event_t e;
        e.kind = kind;
        e.code = code;
        e.is_last = is_last;
        return e;
    endfunction

    function automatic report_t rep(input key_t k0, input key_t k1, input key_t k2,
                                    input key_t k3, input key_t k4, input key_t k5);
        return {k5, k4, k3, k2, k1, k0};
    endfunction

    // n < 0: expectations come from the change predictor
    function automatic void add_row(input report_t rpt, input int n,
                                    input key_event_t e0 = '0, input key_event_t e1 = '0);
        report_row_t row;
        row.typed = (n >= 0);
        row.n = (n >= 0) ? n[1:0] : 2'd0;
        row.e0 = e0;
        row.e1 = e1;
        row.rpt = rpt;
        directed_reports.push_back(row);
    endfunction

    function automatic void predict_key_changes(input report_t rpt);
        key_t fresh[$];
        key_t k;
        int   j;
        predicted_events = {};
        for (int i = 0; i < SLOTS; i++) begin
            k = rpt[i*KEY_W +: KEY_W];
            if (k != '0 && !has_key(fresh, k)) begin
                j = fresh.size();
                fresh.push_back(k);
                while (j > 0 && fresh[j-1] > k) begin
                    fresh[j] = fresh[j-1];
                    j--;
                end
                fresh[j] = k;
            end
        end
        if (held_set.size() == 0 && fresh.size() != 0)
            predicted_events.push_back(ev(EV_MOD_PRESS, '0, 1'b0));
        foreach (fresh[i])
            if (!has_key(held_set, fresh[i]))
                predicted_events.push_back(ev(EV_PRESS, fresh[i], 1'b0));
        foreach (held_set[i])
            if (!has_key(fresh, held_set[i]))
                predicted_events.push_back(ev(EV_RELEASE, held_set[i], 1'b0));
        if (held_set.size() != 0 && fresh.size() == 0)
            predicted_events.push_back(ev(EV_MOD_RELEASE, '0, 1'b0));
        if (predicted_events.size() > 0)
            predicted_events[predicted_events.size()-1].is_last = 1'b1;
        held_set = fresh;
    endfunction

    function automatic report_t random_report(input report_t prev);
        report_t r;
        int      mode;
        int      slot;
        mode = $urandom_range(0, 99);
        r = '0;
        if (mode < 8) begin
            r = '0;
        end else if (mode < 16) begin
            r = {prev[KEY_W-1:0], prev[SLOTS*KEY_W-1:KEY_W]};
        end else if (mode < 28) begin
            r = prev;
            slot = $urandom_range(0, SLOTS-1);
            r[slot*KEY_W +: KEY_W] = ($urandom_range(0, 3) == 0) ? key_t'(0)
                                                                : key_t'($urandom_range(1, 10));
        end else if (mode < 82) begin
            for (int i = 0; i < SLOTS; i++)
                r[i*KEY_W +: KEY_W] = ($urandom_range(0, 2) == 0) ? key_t'(0)
                                                                 : key_t'($urandom_range(1, 10));
        end else begin
            for (int i = 0; i < SLOTS; i++)
                r[i*KEY_W +: KEY_W] = ($urandom_range(0, 3) == 0) ? key_t'(0)
                                                                 : key_t'($urandom);
        end
        return r;
    endfunction

    task automatic send_report(input report_row_t row);
        while (!quiet && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = {$urandom, $urandom, $urandom};
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = row.rpt;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        predict_key_changes(row.rpt);
        if (row.typed) begin
            if (row.n > 0)
                pending_events.push_back(row.e0);
            if (row.n > 1)
                pending_events.push_back(row.e1);
        end else begin
            foreach (predicted_events[i])
                pending_events.push_back(predicted_events[i]);
        end
        @(negedge aclk);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready = quiet || ($urandom_range(0, 99) >= 17);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d key %h last %b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_events.pop_front();
                if (want.kind !== m_axis_tuser || want.code !== m_axis_tdata ||
                    want.is_last !== m_axis_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("event mismatch: expected kind %0d key %h last %b,",
                                 want.kind, want.code, want.is_last,
                                 " got kind %0d key %h last %b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge aresetn);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[hid_key_report_change_events_top] ERROR");
        $finish;
    end

    initial begin
        report_row_t row;
        report_t     prev;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        quiet = 1'b0;
        mismatches = 0;

        add_row(rep(0, 0, 0, 0, 0, 0), 0);
        add_row(rep(16'h0004, 0, 0, 0, 0, 0), 2,
                ev(EV_MOD_PRESS, 16'h0000, 1'b0), ev(EV_PRESS, 16'h0004, 1'b1));
        add_row(rep(0, 0, 16'h0004, 0, 0, 0), 0);
        add_row(rep(16'h0004, 16'h0004, 16'h0004, 16'h0004, 16'h0004, 16'h0004), 0);
        add_row(rep(0, 0, 0, 0, 0, 0), 2,
                ev(EV_RELEASE, 16'h0004, 1'b0), ev(EV_MOD_RELEASE, 16'h0000, 1'b1));
        add_row(rep(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 2,
                ev(EV_MOD_PRESS, 16'h0000, 1'b0), ev(EV_PRESS, 16'hFFFF, 1'b1));
        add_row(rep(16'h0001, 16'hFFFF, 0, 0, 0, 16'h0001), 1,
                ev(EV_PRESS, 16'h0001, 1'b1));
        add_row(rep(16'hFFFF, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001), -1);
        add_row(rep(16'h0007, 16'h0006, 16'h0005, 16'h0004, 16'h0003, 16'h0002), -1);
        add_row(rep(0, 0, 0, 0, 0, 0), -1);
        add_row(rep(0, 0, 0, 0, 0, 16'h0002), 2,
                ev(EV_MOD_PRESS, 16'h0000, 1'b0), ev(EV_PRESS, 16'h0002, 1'b1));
        add_row(rep(0, 0, 0, 16'h0003, 0, 0), 2,
                ev(EV_PRESS, 16'h0003, 1'b0), ev(EV_RELEASE, 16'h0002, 1'b1));
        add_row(rep(16'h0003, 0, 16'h0003, 0, 16'h0009, 16'h0009), 1,
                ev(EV_PRESS, 16'h0009, 1'b1));
        add_row(rep(16'h0009, 16'h0003, 16'h0009, 16'h0003, 16'h0009, 16'h0003), 0);
        add_row(rep(16'hFFFE, 16'hFFFD, 16'h0007, 16'h0008, 16'hC000, 16'h1000), -1);
        add_row(rep(0, 0, 0, 0, 0, 0), -1);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_reports[i])
            send_report(directed_reports[i]);

        prev = '0;
        for (int i = 0; i < RANDOM_REPORTS; i++) begin
            if (i == 50 || i == 200) begin
                s_axis_tvalid = 1'b0;
                wait (pending_events.size() == 0);
                @(negedge aclk);
            end
            quiet = (i >= 100 && i < 160);
            row = '0;
            row.rpt = random_report(prev);
            prev = row.rpt;
            send_report(row);
        end
        s_axis_tvalid = 1'b0;
        quiet = 1'b0;

        wait (pending_events.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("[hid_key_report_change_events_top] OK");
        else
            $display("[hid_key_report_change_events_top] ERROR");
        $finish;
    end

endmodule
